[design/affine_tile_background_pixel_unit_defines.svh]
// Assertion macros shared by the affine tile background pixel unit.
`ifndef AFFINE_TILE_BACKGROUND_PIXEL_UNIT_DEFINES_SVH
`define AFFINE_TILE_BACKGROUND_PIXEL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define ATBP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atbp assertion failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define ATBP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atbp assertion failed");
`else
`define ATBP_ASSERT_IMP(label, ante, cons)
`define ATBP_ASSERT_NXT(label, ante, cons)
`endif

`endif

[design/atbp_pkg.sv]
// Types and constants of the affine tile background pixel unit.
package atbp_pkg;

    localparam int MEM_WORDS = 16384;
    localparam int MEM_AW    = 14;
    localparam int LINE_LAST = 223;
    localparam int CFG_IW    = 3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [CFG_IW-1:0] CFG_MATRIX_A = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_MATRIX_B = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_MATRIX_C = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_MATRIX_D = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CENTER_X = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_CENTER_Y = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_SCROLL_X = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_SCROLL_Y = 3'd7;

    typedef struct packed {
        logic              operation;
        logic [MEM_AW-1:0] mem_address;
        logic [15:0]       mem_data;
        logic [7:0]        line;
        logic [7:0]        column;
        logic              flip_vertical;
        logic              flip_horizontal;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_column;
        logic [7:0] color_index;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] matrix_a;
        logic signed [15:0] matrix_b;
        logic signed [15:0] matrix_c;
        logic signed [15:0] matrix_d;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] scroll_x;
        logic signed [15:0] scroll_y;
    } cfg_t;

    // Item handed from the transform pipeline to the memory fetch pipeline.
    typedef struct packed {
        logic              operation;
        logic [MEM_AW-1:0] mem_address;
        logic [15:0]       mem_data;
        logic [7:0]        pixel_column;
        logic [9:0]        src_x;
        logic [9:0]        src_y;
    } xf_item_t;

endpackage

[design/atbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module atbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/atbp_xform.sv]
// Three-stage coordinate transform: offsets, matrix products, wrapped source position.
module atbp_xform (
    input  logic               clk,
    input  logic               rst_n,
    input  atbp_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  atbp_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output atbp_pkg::xf_item_t out_data
);

    import atbp_pkg::*;

    logic en1, en2, en3;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;

    logic              s1_op_reg, s2_op_reg, s3_op_reg;
    logic [MEM_AW-1:0] s1_addr_reg, s2_addr_reg, s3_addr_reg;
    logic [15:0]       s1_data_reg, s2_data_reg, s3_data_reg;
    logic [7:0]        s1_col_reg, s2_col_reg, s3_col_reg;

    logic [11:0] s1_xoff_reg, s1_xoff_next;
    logic [11:0] s1_row_reg, s1_row_next;
    logic [7:0]  s1_col_next;

    logic [17:0] s2_pa_reg, s2_pa_next;
    logic [17:0] s2_pb_reg, s2_pb_next;
    logic [17:0] s2_pc_reg, s2_pc_next;
    logic [17:0] s2_pd_reg, s2_pd_next;

    logic [9:0] s3_px_reg, s3_px_next;
    logic [9:0] s3_py_reg, s3_py_next;

    logic [13:0] diff_x, diff_y;
    logic [11:0] hoff, voff, row_base;
    logic [17:0] sum_x, sum_y;

    // A stage moves when the stage after it is empty or moving too.
    assign en3      = !s3_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    // Offsets keep ten bits and take bit 13 as the sign.
    always_comb
    begin
        diff_x   = cfg.scroll_x[13:0] - cfg.center_x[13:0];
        diff_y   = cfg.scroll_y[13:0] - cfg.center_y[13:0];
        hoff     = {diff_x[13], diff_x[13], diff_x[9:0]};
        voff     = {diff_y[13], diff_y[13], diff_y[9:0]};
        row_base = in_data.flip_vertical ? (12'(LINE_LAST) - {4'b0000, in_data.line})
                                         : {4'b0000, in_data.line};
        s1_row_next  = row_base + voff;
        s1_xoff_next = hoff + {4'b0000, in_data.column};
        s1_col_next  = in_data.flip_horizontal ? ~in_data.column : in_data.column;
    end

    // Only the low 18 bits of each product reach the wrapped coordinate.
    always_comb
    begin
        s2_pa_next = {{2{cfg.matrix_a[15]}}, cfg.matrix_a} * {{6{s1_xoff_reg[11]}}, s1_xoff_reg};
        s2_pb_next = {{2{cfg.matrix_b[15]}}, cfg.matrix_b} * {{6{s1_row_reg[11]}}, s1_row_reg};
        s2_pc_next = {{2{cfg.matrix_c[15]}}, cfg.matrix_c} * {{6{s1_xoff_reg[11]}}, s1_xoff_reg};
        s2_pd_next = {{2{cfg.matrix_d[15]}}, cfg.matrix_d} * {{6{s1_row_reg[11]}}, s1_row_reg};
    end

    always_comb
    begin
        sum_x      = s2_pa_reg + s2_pb_reg + {cfg.center_x[9:0], 8'h00};
        sum_y      = s2_pc_reg + s2_pd_reg + {cfg.center_y[9:0], 8'h00};
        s3_px_next = sum_x[17:8];
        s3_py_next = sum_y[17:8];
    end

    always_comb
    begin
        s1_valid_next = en1 ? in_valid : s1_valid_reg;
        s2_valid_next = en2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = en3 ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_op_reg   <= in_data.operation;
            s1_addr_reg <= in_data.mem_address;
            s1_data_reg <= in_data.mem_data;
            s1_col_reg  <= s1_col_next;
            s1_xoff_reg <= s1_xoff_next;
            s1_row_reg  <= s1_row_next;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_addr_reg <= s1_addr_reg;
            s2_data_reg <= s1_data_reg;
            s2_col_reg  <= s1_col_reg;
            s2_pa_reg   <= s2_pa_next;
            s2_pb_reg   <= s2_pb_next;
            s2_pc_reg   <= s2_pc_next;
            s2_pd_reg   <= s2_pd_next;
        end
        if (en3 && s2_valid_reg)
        begin
            s3_op_reg   <= s2_op_reg;
            s3_addr_reg <= s2_addr_reg;
            s3_data_reg <= s2_data_reg;
            s3_col_reg  <= s2_col_reg;
            s3_px_reg   <= s3_px_next;
            s3_py_reg   <= s3_py_next;
        end
    end

    assign out_valid             = s3_valid_reg;
    assign out_data.operation    = s3_op_reg;
    assign out_data.mem_address  = s3_addr_reg;
    assign out_data.mem_data     = s3_data_reg;
    assign out_data.pixel_column = s3_col_reg;
    assign out_data.src_x        = s3_px_reg;
    assign out_data.src_y        = s3_py_reg;

endmodule

[design/atbp_fetch.sv]
// Two-stage video memory fetch: tilemap read, then character pixel read.
module atbp_fetch (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  atbp_pkg::xf_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output atbp_pkg::out_item_t out_data
);

    import atbp_pkg::*;

    logic en4, en5;
    logic s5_full;

    logic s4_valid_reg, s4_valid_next;
    logic s5_valid_reg, s5_valid_next;

    logic              s4_op_reg, s5_op_reg;
    logic [MEM_AW-1:0] s4_addr_reg;
    logic [7:0]        s4_hi_reg;
    logic [7:0]        s4_col_reg, s5_col_reg;
    logic [2:0]        s4_fx_reg, s4_fy_reg;

    logic              map_we, map_re, chr_we, chr_re;
    logic [MEM_AW-1:0] map_raddr, chr_raddr;
    logic [7:0]        tile, color;

    // A write item in the last stage holds no result and may be overwritten.
    assign s5_full  = s5_valid_reg && (s5_op_reg == OP_RENDER);
    assign en5      = !s5_full || out_ready;
    assign en4      = !s4_valid_reg || en5;
    assign in_ready = en4;

    // Each RAM is written at the stage where it is read, so every item sees
    // exactly the writes that were accepted before it.
    assign map_we    = in_valid && en4 && (in_data.operation == OP_WRITE);
    assign map_re    = in_valid && en4 && (in_data.operation == OP_RENDER);
    assign map_raddr = {in_data.src_y[9:3], in_data.src_x[9:3]};

    assign chr_we    = s4_valid_reg && en5 && (s4_op_reg == OP_WRITE);
    assign chr_re    = s4_valid_reg && en5 && (s4_op_reg == OP_RENDER);
    assign chr_raddr = {tile, s4_fy_reg, s4_fx_reg};

    atbp_ram #(
        .WIDTH (8),
        .DEPTH (MEM_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (in_data.mem_address),
        .wdata (in_data.mem_data[7:0]),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (tile)
    );

    atbp_ram #(
        .WIDTH (8),
        .DEPTH (MEM_WORDS)
    ) u_chr_ram (
        .clk   (clk),
        .we    (chr_we),
        .waddr (s4_addr_reg),
        .wdata (s4_hi_reg),
        .re    (chr_re),
        .raddr (chr_raddr),
        .rdata (color)
    );

    always_comb
    begin
        s4_valid_next = en4 ? in_valid : s4_valid_reg;
        s5_valid_next = en5 ? s4_valid_reg : s5_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && in_valid)
        begin
            s4_op_reg   <= in_data.operation;
            s4_addr_reg <= in_data.mem_address;
            s4_hi_reg   <= in_data.mem_data[15:8];
            s4_col_reg  <= in_data.pixel_column;
            s4_fx_reg   <= in_data.src_x[2:0];
            s4_fy_reg   <= in_data.src_y[2:0];
        end
        if (en5 && s4_valid_reg)
        begin
            s5_op_reg  <= s4_op_reg;
            s5_col_reg <= s4_col_reg;
        end
    end

    assign out_valid             = s5_full;
    assign out_data.pixel_column = s5_col_reg;
    assign out_data.color_index  = color;

endmodule

[design/affine_tile_background_pixel_unit.sv]
// Top level of the affine tile background pixel unit: register file and pipeline.
// A render's pixel passes through stages s1 to s5 and is presented at the output from s5.
// Throughput: one item per cycle without output stalls; five stages, a memory port per read.
// Write items take the same path and update video memory in order with the renders.
// Reset clears all configuration registers and pipeline valid bits; memory is not cleared.
`include "affine_tile_background_pixel_unit_defines.svh"

module affine_tile_background_pixel_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  atbp_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output atbp_pkg::out_item_t         out_data,
    input  logic                        cfg_write_en,
    input  logic [atbp_pkg::CFG_IW-1:0] cfg_index,
    input  logic [15:0]                 cfg_data
);

    import atbp_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    xf_item_t xf_data;
    logic     xf_valid, xf_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_MATRIX_A: cfg_next.matrix_a = cfg_data;
                CFG_MATRIX_B: cfg_next.matrix_b = cfg_data;
                CFG_MATRIX_C: cfg_next.matrix_c = cfg_data;
                CFG_MATRIX_D: cfg_next.matrix_d = cfg_data;
                CFG_CENTER_X: cfg_next.center_x = cfg_data;
                CFG_CENTER_Y: cfg_next.center_y = cfg_data;
                CFG_SCROLL_X: cfg_next.scroll_x = cfg_data;
                CFG_SCROLL_Y: cfg_next.scroll_y = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    atbp_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (xf_valid),
        .out_ready (xf_ready),
        .out_data  (xf_data)
    );

    atbp_fetch u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xf_valid),
        .in_ready  (xf_ready),
        .in_data   (xf_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The pipeline only refuses input when a finished pixel is waiting.
    `ATBP_ASSERT_IMP(a_stall_means_blocked, !in_ready, !out_ready)
    `ATBP_ASSERT_NXT(a_stall_keeps_result, !in_ready, out_valid)
    // With the output drained every cycle, a render reaches the output after passing stages s1 to s5.
    `ATBP_ASSERT_IMP(a_render_latency, $past(in_valid && in_ready && in_data.operation == OP_RENDER, 5) && $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3) && $past(out_ready, 4) && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) && $past(rst_n, 5), out_valid && out_data.pixel_column == $past(in_data.flip_horizontal ? ~in_data.column : in_data.column, 5))

endmodule

[verif/affine_tile_background_pixel_unit_tb.sv]
// Self-checking testbench for the affine tile background pixel unit.
`timescale 1ns / 1ps

module affine_tile_background_pixel_unit_tb;
    import atbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 240;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_data;
    logic              cfg_write_en;
    logic [CFG_IW-1:0] cfg_index;
    logic [15:0]       cfg_data;

    bit          in_gaps_on;
    bit          out_stalls_on;
    int unsigned idle_cycles;
    int unsigned items_sent;

    // Holds the register and memory image of the block and the pixels still owed by it.
    class pixel_scoreboard;
        cfg_t        regs = '0;
        logic [15:0] vram [MEM_WORDS];
        bit          written [MEM_WORDS];
        out_item_t   pixels_due [$];
        int unsigned failures;

        function void set_reg(logic [CFG_IW-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_MATRIX_A: regs.matrix_a = val;
                CFG_MATRIX_B: regs.matrix_b = val;
                CFG_MATRIX_C: regs.matrix_c = val;
                CFG_MATRIX_D: regs.matrix_d = val;
                CFG_CENTER_X: regs.center_x = val;
                CFG_CENTER_Y: regs.center_y = val;
                CFG_SCROLL_X: regs.scroll_x = val;
                CFG_SCROLL_Y: regs.scroll_y = val;
                default: ;
            endcase
        endfunction

        // Bits 10 to 12 of an offset are dropped and bit 13 acts as its sign.
        function logic signed [63:0] wrap_offset(logic signed [63:0] v);
            logic signed [63:0] low;
            low = {54'd0, v[9:0]};
            return v[13] ? low - 64'sd1024 : low;
        endfunction

        function void predict_fetch(input in_item_t it, output logic [13:0] map_a,
                                    output logic [13:0] chr_a);
            logic signed [63:0] ma, mb, mc, md, cx, cy, hx, vy;
            logic signed [63:0] row, xoff, sum_x, sum_y;
            logic [9:0]         px, py;
            logic [7:0]         tile;
            ma = regs.matrix_a;
            mb = regs.matrix_b;
            mc = regs.matrix_c;
            md = regs.matrix_d;
            cx = regs.center_x;
            cy = regs.center_y;
            hx = regs.scroll_x;
            vy = regs.scroll_y;
            row = {56'd0, it.line};
            // Lines past the last visible one give a negative row when flipped.
            if (it.flip_vertical)
                row = LINE_LAST - row;
            row = row + wrap_offset(vy - cy);
            xoff = wrap_offset(hx - cx) + {56'd0, it.column};
            sum_x = ma * xoff + mb * row + cx * 256;
            sum_y = mc * xoff + md * row + cy * 256;
            px = sum_x[17:8];
            py = sum_y[17:8];
            map_a = {py[9:3], px[9:3]};
            tile = vram[map_a][7:0];
            chr_a = {tile, py[2:0], px[2:0]};
        endfunction

        function void note_transfer(in_item_t it);
            logic [13:0] map_a, chr_a;
            out_item_t   want;
            if (it.operation == OP_WRITE) begin
                vram[it.mem_address] = it.mem_data;
                written[it.mem_address] = 1'b1;
            end
            else begin
                predict_fetch(it, map_a, chr_a);
                want.pixel_column = it.flip_horizontal ? 8'd255 - it.column : it.column;
                want.color_index = vram[chr_a][15:8];
                pixels_due.push_back(want);
            end
        endfunction

        function void check_pixel(out_item_t got);
            out_item_t want;
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected pixel: expected none, actual column %0d color %0d",
                         $time, got.pixel_column, got.color_index);
                failures++;
                return;
            end
            want = pixels_due.pop_front();
            if (got.pixel_column !== want.pixel_column) begin
                $display("%0t: pixel_column mismatch: expected %0d, actual %0d",
                         $time, want.pixel_column, got.pixel_column);
                failures++;
            end
            if (got.color_index !== want.color_index) begin
                $display("%0t: color_index mismatch: expected %0d, actual %0d",
                         $time, want.color_index, got.color_index);
                failures++;
            end
        endfunction
    endclass

    pixel_scoreboard board = new();

    affine_tile_background_pixel_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && in_ready)
                board.note_transfer(in_data);
            if (out_valid && out_ready)
                board.check_pixel(out_data);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always
    begin
        int unsigned n;
        @(negedge clk);
        n = out_stalls_on ? gap_len() : 0;
        if (n > 0)
        begin
            out_ready = 1'b0;
            repeat (n) @(negedge clk);
        end
        out_ready = 1'b1;
    end

    function automatic in_item_t random_render();
        in_item_t it;
        it.operation = OP_RENDER;
        it.mem_address = MEM_AW'($urandom_range(0, MEM_WORDS - 1));
        it.mem_data = 16'($urandom_range(0, 65535));
        it.line = 8'($urandom_range(0, 239));
        it.column = 8'($urandom_range(0, 255));
        it.flip_vertical = 1'($urandom_range(0, 1));
        it.flip_horizontal = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic logic [15:0] pick_value(bit mild);
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return mild ? 16'($urandom_range(0, 1023)) - 16'd512 : 16'($urandom);
        endcase
    endfunction

    function automatic cfg_t random_config(bit mild);
        cfg_t c;
        c.matrix_a = pick_value(mild);
        c.matrix_b = pick_value(mild);
        c.matrix_c = pick_value(mild);
        c.matrix_d = pick_value(mild);
        c.center_x = pick_value(mild);
        c.center_y = pick_value(mild);
        c.scroll_x = pick_value(mild);
        c.scroll_y = pick_value(mild);
        return c;
    endfunction

    // Entered and left at a falling edge; valid stays high on return for a back-to-back transfer.
    task automatic send_item(in_item_t item);
        int unsigned n;
        n = in_gaps_on ? gap_len() : 0;
        if (n > 0)
        begin
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
        in_data = item;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_word(logic [13:0] addr, logic [15:0] data);
        in_item_t it;
        it = random_render();
        it.operation = OP_WRITE;
        it.mem_address = addr;
        it.mem_data = data;
        send_item(it);
    endtask

    // Both words that a render reads are written first if they still hold nothing defined.
    task automatic render_pixel(in_item_t item);
        logic [13:0] map_a, chr_a;
        board.predict_fetch(item, map_a, chr_a);
        if (!board.written[map_a])
            write_word(map_a, 16'($urandom));
        board.predict_fetch(item, map_a, chr_a);
        if (!board.written[chr_a])
            write_word(chr_a, 16'($urandom));
        send_item(item);
    endtask

    task automatic render_at(int ln, int col, bit vf, bit hf);
        in_item_t it;
        it = random_render();
        it.line = 8'(ln);
        it.column = 8'(col);
        it.flip_vertical = vf;
        it.flip_horizontal = hf;
        render_pixel(it);
    endtask

    // Writes produce no pixel, so the wait goes on for DRAIN_CYCLES to let the last of them retire.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (board.pixels_due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(logic [CFG_IW-1:0] idx, logic [15:0] val);
        cfg_write_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        board.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic load_config(cfg_t c);
        put_reg(CFG_MATRIX_A, c.matrix_a);
        put_reg(CFG_MATRIX_B, c.matrix_b);
        put_reg(CFG_MATRIX_C, c.matrix_c);
        put_reg(CFG_MATRIX_D, c.matrix_d);
        put_reg(CFG_CENTER_X, c.center_x);
        put_reg(CFG_CENTER_Y, c.center_y);
        put_reg(CFG_SCROLL_X, c.scroll_x);
        put_reg(CFG_SCROLL_Y, c.scroll_y);
        cfg_write_en = 1'b0;
    endtask

    task automatic render_corners();
        render_at(0, 0, 1'b0, 1'b0);
        render_at(239, 255, 1'b0, 1'b0);
        render_at(120, 128, 1'b1, 1'b1);
    endtask

    initial
    begin
        cfg_t        c;
        int unsigned target;
        int unsigned pause_at;
        bit          paused;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extreme addresses and data, then one render at the reset settings.
        write_word(14'h3FFF, 16'h0000);
        write_word(14'h0000, 16'hFFFF);
        write_word(14'h2AAA, 16'h5555);
        write_word(14'h1555, 16'hAAAA);
        render_at(0, 0, 1'b0, 1'b0);

        // Identity matrix; scroll_x has junk in bits 10 to 12, scroll_y has bit 13 set.
        wait_idle();
        c.matrix_a = 16'h0100;
        c.matrix_b = 16'h0000;
        c.matrix_c = 16'h0000;
        c.matrix_d = 16'h0100;
        c.center_x = 16'h0080;
        c.center_y = 16'h0040;
        c.scroll_x = 16'h1C05;
        c.scroll_y = 16'h2003;
        load_config(c);
        render_at(0, 0, 1'b0, 1'b0);
        render_at(239, 255, 1'b1, 1'b1);
        render_at(223, 17, 1'b1, 1'b0);
        render_at(224, 3, 1'b1, 1'b0);
        render_at(100, 0, 1'b0, 1'b1);
        render_at(5, 255, 1'b0, 1'b1);

        wait_idle();
        c = '{default: 16'h8000};
        load_config(c);
        render_corners();

        wait_idle();
        c = '{default: 16'h7FFF};
        load_config(c);
        render_corners();

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            load_config(random_config(p < 3));
            in_gaps_on = (p % 4) < 2;
            out_stalls_on = (p % 2) == 0;
            target = items_sent + PHASE_ITEMS;
            pause_at = items_sent + $urandom_range(50, 200);
            paused = 1'b0;
            while (items_sent < target)
            begin
                // Hold the sender once per phase until every pixel has come out.
                if (!paused && items_sent >= pause_at)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                    write_word(14'($urandom_range(0, MEM_WORDS - 1)), 16'($urandom));
                else
                    render_pixel(random_render());
            end
        end

        wait_idle();
        if (board.failures == 0 && board.pixels_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
